/* rtl/skm_pkg.sv */
// ----------------------------------------------------------------------------
// skm_pkg
// Types, register map and column unpack table for the key state merger.
// ----------------------------------------------------------------------------
package skm_pkg;

  localparam int unsigned NumCols   = 10;
  localparam int unsigned ColW      = 5;
  localparam int unsigned ColBits   = 5;
  localparam int unsigned PayloadW  = 24;
  localparam int unsigned CountW    = 17;
  localparam int unsigned LimitW    = 16;

  localparam logic [3:0] LastIdx = 4'd10;

  localparam logic [1:0] REQ_HOST  = 2'd0;
  localparam logic [1:0] REQ_LEFT  = 2'd1;
  localparam logic [1:0] REQ_RIGHT = 2'd2;

  localparam logic [1:0] REG_LIMIT    = 2'd0;
  localparam logic [1:0] REG_END_BYTE = 2'd1;
  localparam logic [1:0] REG_SEND_CMD = 2'd2;

  localparam logic [15:0] LIMIT_RST    = 16'd10000;
  localparam logic [7:0]  END_BYTE_RST = 8'hE0;
  localparam logic [7:0]  SEND_CMD_RST = 8'h73;

  localparam logic [4:0] NO_BIT = 5'd31;

  localparam logic [4:0] COL_MAP [NumCols][ColBits] = '{
    '{5'd3,  5'd4,  5'd5,  5'd6,  5'd7},
    '{5'd7,  5'd6,  5'd5,  5'd4,  5'd3},
    '{5'd14, 5'd15, 5'd0,  5'd1,  5'd2},
    '{5'd2,  5'd1,  5'd0,  5'd15, 5'd14},
    '{5'd9,  5'd10, 5'd11, 5'd12, 5'd13},
    '{5'd13, 5'd12, 5'd11, 5'd10, 5'd9},
    '{NO_BIT, 5'd21, 5'd22, 5'd23, 5'd8},
    '{5'd8,  5'd23, 5'd22, 5'd21, NO_BIT},
    '{NO_BIT, 5'd17, 5'd18, 5'd19, 5'd20},
    '{5'd20, 5'd19, 5'd18, 5'd17, NO_BIT}
  };

  typedef logic [NumCols-1:0][ColW-1:0] frame_t;

  typedef struct packed {
    logic [LimitW-1:0] limit;
    logic [7:0]        send_cmd;
  } cfg_t;

  function automatic logic [ColW-1:0] unpack_col(input logic [PayloadW-1:0] p,
                                                 input logic [3:0] slot);
    logic [ColW-1:0] col;
    logic [4:0]      src;
    col = '0;
    for (int b = 0; b < ColBits; b++) begin
      src = COL_MAP[slot][b];
      if (src != NO_BIT) begin
        col[b] = p[src];
      end
    end
    return col;
  endfunction

endpackage

/* rtl/split_keyboard_state_merger.sv */
// ----------------------------------------------------------------------------
// split_keyboard_state_merger
// Merges the key state of two keyboard halves into frames for the host.
// ----------------------------------------------------------------------------
// Input words are taken one per cycle as long as the frame queue has room;
// packet and plain host bytes never wait otherwise. Each send command puts a
// snapshot of the ten key columns into a queue of QueueDepth frames, and the
// output serializer sends that frame as eleven words, one per cycle while the
// output is ready. Registers sit on an APB port at 0x0 (idle limit), 0x4 (end
// byte) and 0x8 (send command).
module split_keyboard_state_merger #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  host_byte_i,
  input  logic [7:0]  payload_first_i,
  input  logic [7:0]  payload_second_i,
  input  logic [7:0]  payload_third_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic        frame_last_o
);

  logic [15:0]     limit_q;
  logic [7:0]      end_byte_q, send_cmd_q;
  logic            wr_en;
  skm_pkg::cfg_t   cfg;
  logic            q_full, q_push, q_pop, q_valid;
  skm_pkg::frame_t q_push_data, q_head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= skm_pkg::LIMIT_RST;
      end_byte_q <= skm_pkg::END_BYTE_RST;
      send_cmd_q <= skm_pkg::SEND_CMD_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        skm_pkg::REG_LIMIT:    limit_q    <= pwdata[15:0];
        skm_pkg::REG_END_BYTE: end_byte_q <= pwdata[7:0];
        skm_pkg::REG_SEND_CMD: send_cmd_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      skm_pkg::REG_LIMIT:    prdata = {16'd0, limit_q};
      skm_pkg::REG_END_BYTE: prdata = {24'd0, end_byte_q};
      skm_pkg::REG_SEND_CMD: prdata = {24'd0, send_cmd_q};
      default:               prdata = '0;
    endcase
  end

  assign cfg.limit    = limit_q;
  assign cfg.send_cmd = send_cmd_q;

  skm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .host_byte_i      (host_byte_i),
    .payload_first_i  (payload_first_i),
    .payload_second_i (payload_second_i),
    .payload_third_i  (payload_third_i),
    .q_full_i         (q_full),
    .push_o           (q_push),
    .push_data_o      (q_push_data)
  );

  skm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  skm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .end_byte_i   (end_byte_q),
    .q_valid_i    (q_valid),
    .q_head_i     (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .frame_last_o (frame_last_o)
  );

endmodule

/* rtl/skm_front.sv */
// ----------------------------------------------------------------------------
// skm_front
// Accepts items, keeps payloads, columns and idle counts, and pushes a
// column snapshot into the frame queue for each send command.
// ----------------------------------------------------------------------------
module skm_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  skm_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic [7:0]                        host_byte_i,
  input  logic [7:0]                        payload_first_i,
  input  logic [7:0]                        payload_second_i,
  input  logic [7:0]                        payload_third_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output skm_pkg::frame_t                   push_data_o
);

  logic [skm_pkg::PayloadW-1:0] left_q, left_d, right_q, right_d;
  logic                         lfresh_q, lfresh_d, rfresh_q, rfresh_d;
  skm_pkg::frame_t              cols_q, cols_d, cols_unp;
  logic [skm_pkg::CountW-1:0]   lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  logic [skm_pkg::CountW-1:0]   lcnt_inc, rcnt_inc, limit_ext;
  logic [skm_pkg::PayloadW-1:0] payload;
  logic                         acc, is_host;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign is_host    = (req_type_i == skm_pkg::REQ_HOST);
  assign payload    = {payload_third_i, payload_second_i, payload_first_i};
  assign lcnt_inc   = lcnt_q + 1'b1;
  assign rcnt_inc   = rcnt_q + 1'b1;
  assign limit_ext  = {1'b0, cfg_i.limit};

  always_comb begin
    for (int s = 0; s < skm_pkg::NumCols; s++) begin
      if ((s % 2) == 0) begin
        cols_unp[s] = lfresh_q ? skm_pkg::unpack_col(left_q, 4'(s)) : cols_q[s];
      end else begin
        cols_unp[s] = rfresh_q ? skm_pkg::unpack_col(right_q, 4'(s)) : cols_q[s];
      end
    end
  end

  assign push_o      = acc && is_host && (host_byte_i == cfg_i.send_cmd);
  assign push_data_o = cols_unp;

  always_comb begin
    left_d   = left_q;
    right_d  = right_q;
    lfresh_d = lfresh_q;
    rfresh_d = rfresh_q;
    cols_d   = cols_q;
    lcnt_d   = lcnt_q;
    rcnt_d   = rcnt_q;
    if (acc) begin
      case (req_type_i)
        skm_pkg::REQ_LEFT: begin
          left_d   = payload;
          lfresh_d = 1'b1;
          lcnt_d   = '0;
        end
        skm_pkg::REQ_RIGHT: begin
          right_d  = payload;
          rfresh_d = 1'b1;
          rcnt_d   = '0;
        end
        skm_pkg::REQ_HOST: begin
          lfresh_d = 1'b0;
          rfresh_d = 1'b0;
          cols_d   = cols_unp;
          lcnt_d   = lcnt_inc;
          rcnt_d   = rcnt_inc;
          if (lcnt_inc > limit_ext) begin
            lcnt_d = '0;
            for (int s = 0; s < skm_pkg::NumCols; s += 2) begin
              cols_d[s] = '0;
            end
          end
          if (rcnt_inc > limit_ext) begin
            rcnt_d = '0;
            for (int s = 1; s < skm_pkg::NumCols; s += 2) begin
              cols_d[s] = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      right_q  <= '0;
      lfresh_q <= 1'b0;
      rfresh_q <= 1'b0;
      cols_q   <= '0;
      lcnt_q   <= '0;
      rcnt_q   <= '0;
    end else begin
      left_q   <= left_d;
      right_q  <= right_d;
      lfresh_q <= lfresh_d;
      rfresh_q <= rfresh_d;
      cols_q   <= cols_d;
      lcnt_q   <= lcnt_d;
      rcnt_q   <= rcnt_d;
    end
  end

  // a push only happens on an accepted host byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (in_valid_i && !q_full_i && is_host))
    else $error("frame push without accepted host byte");

endmodule

/* rtl/skm_queue.sv */
// ----------------------------------------------------------------------------
// skm_queue
// Small FIFO of column snapshots between the front and the serializer.
// ----------------------------------------------------------------------------
module skm_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  skm_pkg::frame_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output skm_pkg::frame_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  skm_pkg::frame_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full frame queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && valid_o) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("frame queue count lost a push");

endmodule

/* rtl/skm_back.sv */
// ----------------------------------------------------------------------------
// skm_back
// Serializes one queued frame: ten column bytes then the end byte.
// ----------------------------------------------------------------------------
module skm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      end_byte_i,
  input  logic            q_valid_i,
  input  skm_pkg::frame_t q_head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      frame_byte_o,
  output logic            frame_last_o
);

  logic [3:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       load, at_end;

  assign load   = !vld_q || out_ready_i;
  assign at_end = (idx_q == skm_pkg::LastIdx);
  assign pop_o  = load && q_valid_i && at_end;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    last_d = last_q;
    if (load) begin
      vld_d = q_valid_i;
      if (q_valid_i) begin
        last_d = at_end;
        if (at_end) begin
          byte_d = end_byte_i;
          idx_d  = '0;
        end else begin
          byte_d = {3'b000, q_head_i[idx_q]};
          idx_d  = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o  = vld_q;
  assign frame_byte_o = byte_q;
  assign frame_last_o = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= skm_pkg::LastIdx)
    else $error("byte index past end of frame");

  // the end byte leaves the index back at the first column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && last_q) |-> (idx_q == '0))
    else $error("end byte shown with index not rewound");

endmodule
